### rtl/core/art_pkg.sv
package art_pkg;

   localparam int StateWidth = 64;
   localparam int OpWidth    = 4;

   typedef logic [OpWidth-1:0]    op_type;
   typedef logic [StateWidth-1:0] half_type;
   typedef logic [7:0]            byte_type;

   localparam op_type OpAddKey      = 4'd0;
   localparam op_type OpSubBytes    = 4'd1;
   localparam op_type OpInvSubBytes = 4'd2;
   localparam op_type OpShiftRows   = 4'd3;
   localparam op_type OpInvShift    = 4'd4;
   localparam op_type OpMix         = 4'd5;
   localparam op_type OpInvMix      = 4'd6;
   localparam op_type OpRotWord     = 4'd7;
   localparam op_type OpSubWord     = 4'd8;

   localparam byte_type SboxTable [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam byte_type InvSboxTable [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   // Multiply by two in GF(2^8) with polynomial 0x11b.
   function automatic byte_type xtime(byte_type a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

endpackage

### rtl/core/aes_round_transform_unit.sv
// A start transfer passes through the input register and then the result register, which drives rsp_valid.
// Throughput: one item per cycle; the input register and the result register are the
// only stages, with the whole transform between them.
// busy is always low, and the receiver cannot stall the result strobe.
// Reset (synchronous, active high) clears the valid bits of both stages.
module aes_round_transform_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  art_pkg::op_type   req_op,
   input  art_pkg::half_type req_state_hi,
   input  art_pkg::half_type req_state_lo,
   input  art_pkg::half_type req_round_key_hi,
   input  art_pkg::half_type req_round_key_lo,
   output logic              rsp_valid,
   output art_pkg::half_type rsp_result_hi,
   output art_pkg::half_type rsp_result_lo,
   output logic              rsp_op_error
);
   import art_pkg::*;

   logic     valid_ff, out_valid_ff;
   op_type   op_ff;
   half_type st_hi_ff, st_lo_ff, key_hi_ff, key_lo_ff;
   half_type res_hi_ff, res_lo_ff, res_hi_in, res_lo_in;
   logic     err_ff, err_in;

   byte_type st     [16];
   byte_type sub_b  [16];
   byte_type isub_b [16];
   byte_type shf_b  [16];
   byte_type ishf_b [16];
   byte_type mix_b  [16];
   byte_type imix_b [16];
   logic [127:0] sub_v, isub_v, shf_v, ishf_v, mix_v, imix_v;
   logic [31:0]  word_v, rot_v, subw_v;

   assign busy = 1'b0;

   // Input register: every start transfer is captured.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start;
      end
      op_ff     <= req_op;
      st_hi_ff  <= req_state_hi;
      st_lo_ff  <= req_state_lo;
      key_hi_ff <= req_round_key_hi;
      key_lo_ff <= req_round_key_lo;
   end

   // Byte views and the per-byte transforms.
   always_comb begin
      byte_type a0, a1, a2, a3, d0, d1, d2, d3, q0, q1, q2, q3;
      for (int i = 0; i < 8; i++) begin
         st[i]     = st_hi_ff[63-8*i -: 8];
         st[i + 8] = st_lo_ff[63-8*i -: 8];
      end
      for (int i = 0; i < 16; i++) begin
         sub_b[i]  = SboxTable[st[i]];
         isub_b[i] = InvSboxTable[st[i]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            shf_b[r + 4*c]  = st[r + 4*((c + r) % 4)];
            ishf_b[r + 4*c] = st[r + 4*((c - r + 4) % 4)];
         end
         a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
         mix_b[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         mix_b[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         mix_b[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         mix_b[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
         // Inverse mix: x*2, x*4, x*8 combined into 9, b, d, e.
         d0 = xtime(a0); d1 = xtime(a1); d2 = xtime(a2); d3 = xtime(a3);
         q0 = xtime(d0); q1 = xtime(d1); q2 = xtime(d2); q3 = xtime(d3);
         imix_b[4*c] = (xtime(q0)^q0^d0) ^ (xtime(q1)^d1^a1) ^ (xtime(q2)^q2^a2)
                       ^ (xtime(q3)^a3);
         imix_b[4*c+1] = (xtime(q0)^a0) ^ (xtime(q1)^q1^d1) ^ (xtime(q2)^d2^a2)
                       ^ (xtime(q3)^q3^a3);
         imix_b[4*c+2] = (xtime(q0)^q0^a0) ^ (xtime(q1)^a1) ^ (xtime(q2)^q2^d2)
                       ^ (xtime(q3)^d3^a3);
         imix_b[4*c+3] = (xtime(q0)^d0^a0) ^ (xtime(q1)^q1^a1) ^ (xtime(q2)^a2)
                       ^ (xtime(q3)^q3^d3);
      end
      for (int i = 0; i < 16; i++) begin
         sub_v[127-8*i -: 8]  = sub_b[i];
         isub_v[127-8*i -: 8] = isub_b[i];
         shf_v[127-8*i -: 8]  = shf_b[i];
         ishf_v[127-8*i -: 8] = ishf_b[i];
         mix_v[127-8*i -: 8]  = mix_b[i];
         imix_v[127-8*i -: 8] = imix_b[i];
      end
      word_v = st_lo_ff[31:0];
      rot_v  = {word_v[23:0], word_v[31:24]};
      subw_v = {SboxTable[word_v[31:24]], SboxTable[word_v[23:16]],
                SboxTable[word_v[15:8]], SboxTable[word_v[7:0]]};
   end

   // Operation select.
   always_comb begin
      err_in = 1'b0;
      unique case (op_ff)
         OpAddKey: begin
            res_hi_in = st_hi_ff ^ key_hi_ff;
            res_lo_in = st_lo_ff ^ key_lo_ff;
         end
         OpSubBytes:    {res_hi_in, res_lo_in} = sub_v;
         OpInvSubBytes: {res_hi_in, res_lo_in} = isub_v;
         OpShiftRows:   {res_hi_in, res_lo_in} = shf_v;
         OpInvShift:    {res_hi_in, res_lo_in} = ishf_v;
         OpMix:         {res_hi_in, res_lo_in} = mix_v;
         OpInvMix:      {res_hi_in, res_lo_in} = imix_v;
         OpRotWord: begin
            res_hi_in = '0;
            res_lo_in = {32'd0, rot_v};
         end
         OpSubWord: begin
            res_hi_in = '0;
            res_lo_in = {32'd0, subw_v};
         end
         default: begin
            res_hi_in = st_hi_ff;
            res_lo_in = st_lo_ff;
            err_in    = 1'b1;
         end
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff;
      end
      res_hi_ff <= res_hi_in;
      res_lo_ff <= res_lo_in;
      err_ff    <= err_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_result_hi = res_hi_ff;
   assign rsp_result_lo = res_lo_ff;
   assign rsp_op_error  = err_ff;

   // Every start transfer shows up as a strobe on rsp_valid.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start ##1 !reset |=> rsp_valid)
      else $error("result strobe missing");

   // Word operations clear the upper result bits.
   a_word_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (op_ff == OpRotWord || op_ff == OpSubWord)
      |=> rsp_result_hi == '0 && rsp_result_lo[63:32] == '0)
      else $error("word result upper bits not zero");

   // The error flag is raised exactly for the invalid operation codes.
   a_err_pass: assert property (@(posedge clock) disable iff (reset)
      valid_ff |=> rsp_op_error == ($past(op_ff) > OpSubWord))
      else $error("op_error mismatch");

endmodule

### dv/aes_round_transform_unit_tb.sv
`timescale 1ns / 100ps

module aes_round_transform_unit_tb;
   import art_pkg::*;

   localparam int OpCount = 16;

   typedef struct packed {
      half_type hi;
      half_type lo;
      logic     err;
   } outcome_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   logic     busy;
   op_type   req_op = '0;
   half_type req_state_hi = '0;
   half_type req_state_lo = '0;
   half_type req_round_key_hi = '0;
   half_type req_round_key_lo = '0;
   logic     rsp_valid;
   half_type rsp_result_hi;
   half_type rsp_result_lo;
   logic     rsp_op_error;

   outcome_type pending_outcomes[$];
   int          mismatch_count = 0;
   int          idle_percent = 0;

   aes_round_transform_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_state_hi(req_state_hi), .req_state_lo(req_state_lo),
      .req_round_key_hi(req_round_key_hi), .req_round_key_lo(req_round_key_lo),
      .rsp_valid(rsp_valid), .rsp_result_hi(rsp_result_hi),
      .rsp_result_lo(rsp_result_lo), .rsp_op_error(rsp_op_error)
   );

   always #1 clock = ~clock;

   // Field multiply over GF(2^8), polynomial 0x11b, shift and add.
   function automatic byte_type field_mul(byte_type a, byte_type b);
      byte_type acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return acc;
   endfunction

   // Field inverse as a^254; zero maps to zero.
   function automatic byte_type field_inv(byte_type a);
      byte_type r;
      r = 8'h01;
      for (int i = 0; i < 254; i++) r = field_mul(r, a);
      return r;
   endfunction

   function automatic byte_type rot8(byte_type x, int n);
      return byte_type'((x << n) | (x >> (8 - n)));
   endfunction

   // The S-box from its definition: inverse, then affine map.
   function automatic byte_type forward_sub(byte_type x);
      byte_type b;
      b = field_inv(x);
      return b ^ rot8(b, 1) ^ rot8(b, 2) ^ rot8(b, 3) ^ rot8(b, 4) ^ 8'h63;
   endfunction

   function automatic byte_type reverse_sub(byte_type s);
      return field_inv(rot8(s, 1) ^ rot8(s, 3) ^ rot8(s, 6) ^ 8'h05);
   endfunction

   // Compute the transformed state for one request.
   function automatic outcome_type transform_state(op_type op, half_type s_hi, half_type s_lo,
                                                   half_type k_hi, half_type k_lo);
      outcome_type o;
      byte_type    st[16];
      byte_type    nx[16];
      byte_type    f[4];
      logic [31:0] w;
      int          src;
      for (int i = 0; i < 8; i++) begin
         st[i]     = s_hi[63 - 8*i -: 8];
         st[i + 8] = s_lo[63 - 8*i -: 8];
      end
      nx = st;
      o.err = 1'b0;
      o.hi = s_hi;
      o.lo = s_lo;
      case (op)
         OpAddKey: begin
            o.hi = s_hi ^ k_hi;
            o.lo = s_lo ^ k_lo;
         end
         OpSubBytes, OpInvSubBytes: begin
            for (int i = 0; i < 16; i++)
               nx[i] = (op == OpSubBytes) ? forward_sub(st[i]) : reverse_sub(st[i]);
         end
         OpShiftRows, OpInvShift: begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++) begin
                  src = (op == OpShiftRows) ? ((c + r) & 3) : ((c - r + 4) & 3);
                  nx[r + 4*c] = st[r + 4*src];
               end
         end
         OpMix, OpInvMix: begin
            if (op == OpMix) begin
               f = '{8'h02, 8'h03, 8'h01, 8'h01};
            end else begin
               f = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
            end
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  nx[r + 4*c] = field_mul(st[4*c + r], f[0])
                     ^ field_mul(st[4*c + ((r + 1) & 3)], f[1])
                     ^ field_mul(st[4*c + ((r + 2) & 3)], f[2])
                     ^ field_mul(st[4*c + ((r + 3) & 3)], f[3]);
         end
         OpRotWord: begin
            w = s_lo[31:0];
            o.hi = '0;
            o.lo = {32'h0, w[23:0], w[31:24]};
         end
         OpSubWord: begin
            w = s_lo[31:0];
            o.hi = '0;
            o.lo = {32'h0, forward_sub(w[31:24]), forward_sub(w[23:16]),
                    forward_sub(w[15:8]), forward_sub(w[7:0])};
         end
         default: o.err = 1'b1;
      endcase
      // Byte-wise operations repack the state array.
      if (op inside {OpSubBytes, OpInvSubBytes, OpShiftRows, OpInvShift, OpMix, OpInvMix}) begin
         for (int i = 0; i < 8; i++) begin
            o.hi[63 - 8*i -: 8] = nx[i];
            o.lo[63 - 8*i -: 8] = nx[i + 8];
         end
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Send one request, idling first as the current phase asks.
   task automatic send_request(op_type op, half_type s_hi, half_type s_lo,
                               half_type k_hi, half_type k_lo);
      while ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_state_hi <= s_hi;
      req_state_lo <= s_lo;
      req_round_key_hi <= k_hi;
      req_round_key_lo <= k_lo;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_outcomes.push_back(transform_state(op, s_hi, s_lo, k_hi, k_lo));
   endtask

   // Check each result transfer against the oldest expected outcome.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected result", rsp_result_hi, 64'h0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_result_hi !== want.hi) report_mismatch("result_hi", rsp_result_hi, want.hi);
            if (rsp_result_lo !== want.lo) report_mismatch("result_lo", rsp_result_lo, want.lo);
            if (rsp_op_error !== want.err)
               report_mismatch("op_error", 64'(rsp_op_error), 64'(want.err));
         end
      end
   end

   function automatic half_type random_half();
      return {$urandom(), $urandom()};
   endfunction

   task automatic drain_results();
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Every operation and invalid code with an all-zero state and an all-one key; valid operations also the reverse.
   task automatic test_directed_extremes();
      for (int op = 0; op < OpCount; op++) begin
         send_request(op_type'(op), '0, '0, '1, '1);
         if (op < 9) send_request(op_type'(op), '1, '1, '0, '0);
      end
   endtask

   // Known vector: the first MixColumns column db 13 53 45 maps to 8e 4d a1 bc.
   task automatic test_directed_known();
      send_request(OpMix, 64'hdb135345_f20a225c, 64'h01010101_c6c6c6c6, '0, '0);
      send_request(OpSubWord, random_half(), 64'h0123_4567_89ab_cdef, '0, '0);
   endtask

   // Random requests, mostly valid codes, with an idle mix that varies by phase.
   task automatic test_random_phases();
      int phase_idle[4] = '{0, 55, 0, 38};
      op_type op;
      for (int p = 0; p < 4; p++) begin
         idle_percent = phase_idle[p];
         for (int n = 0; n < 500; n++) begin
            op = ($urandom_range(9) == 0) ? op_type'($urandom_range(15, 9))
                                            : op_type'($urandom_range(8));
            send_request(op, random_half(), random_half(), random_half(), random_half());
         end
         // After the second phase the sender holds off until every expected result has come.
         if (p == 1) drain_results();
      end
      idle_percent = 0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_directed_known();
      test_random_phases();
      drain_results();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
